[hw/rtl/decimal_text_to_integer_top_assert.svh]
// Assertion macros for the decimal text to integer block.
// Used by decimal_text_to_integer_top; expects clk and arst_n in scope.
`ifndef DECIMAL_TEXT_TO_INTEGER_TOP_ASSERT_SVH
`define DECIMAL_TEXT_TO_INTEGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DTOI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DTOI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dtoi_pkg.sv]
// Package for the decimal text to integer block: parse phase, status codes,
// control struct and character / limit constants. No dependencies.
`default_nettype none

package dtoi_pkg;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 1'b1;

	// width_select codes; any other code means 64 bits
	localparam logic [1:0] WS_16 = 2'd0;
	localparam logic [1:0] WS_32 = 2'd1;
	localparam logic [1:0] WS_64 = 2'd2;

	localparam logic [VALUE_W-1:0] UMAX_16 = 64'h0000_0000_0000_FFFF;
	localparam logic [VALUE_W-1:0] UMAX_32 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] UMAX_64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] SMIN_16 = 64'h0000_0000_0000_8000;
	localparam logic [VALUE_W-1:0] SMIN_32 = 64'h0000_0000_8000_0000;
	localparam logic [VALUE_W-1:0] SMIN_64 = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_MINUS  = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_START = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_TOO_SMALL = 3'd3,
		ST_TRAILING  = 3'd4,
		ST_WIDTH     = 3'd5
	} status_t;

	typedef struct packed {
		phase_t  phase;
		logic    negative;
		status_t first_error;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = '{phase: PH_START, negative: 1'b0, first_error: ST_OK};

endpackage

`default_nettype wire

[hw/rtl/dtoi_step.sv]
// Per-character parse step: next phase, sign, first error and accumulator.
// Depends on dtoi_pkg.
`default_nettype none

module dtoi_step import dtoi_pkg::*; #(
	parameter int ACC_BITS = 64
) (
	input  wire logic [CHAR_W-1:0]   char_in,
	input  wire logic                signed_mode,
	input  wire ctrl_t               ctrl_cur,
	input  wire logic [ACC_BITS-1:0] acc_cur,
	output ctrl_t                    ctrl_nxt,
	output logic [ACC_BITS-1:0]      acc_nxt
);

	localparam int EW = ACC_BITS + 4;

	logic          is_digit;
	logic          is_minus;
	logic          sgn;
	logic [EW-1:0] acc_ext;
	logic [EW-1:0] prod;
	logic [EW-1:0] lim;
	logic [EW-1:0] half;
	logic          ovf;

	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_minus = (char_in == CH_MINUS);
	assign sgn      = ctrl_cur.negative || signed_mode;

	// acc*10 + d without a multiplier; overflow when past the magnitude limit
	assign acc_ext = EW'(acc_cur);
	assign prod    = (acc_ext << 3) + (acc_ext << 1) + EW'(char_in[3:0]);
	assign half    = EW'(1) << (ACC_BITS - 1);

	always_comb begin
		if (!sgn) begin
			lim = EW'({ACC_BITS{1'b1}});
		end else if (ctrl_cur.negative) begin
			lim = half;
		end else begin
			lim = half - EW'(1);
		end
	end

	assign ovf = prod > lim;

	always_comb begin
		ctrl_nxt = ctrl_cur;
		acc_nxt  = acc_cur;
		case (ctrl_cur.phase)
			PH_START, PH_MINUS, PH_DIGITS: begin
				if (is_digit) begin
					if (ovf) begin
						ctrl_nxt.phase = PH_SKIP;
						if (ctrl_cur.first_error == ST_OK) begin
							ctrl_nxt.first_error = ctrl_cur.negative ? ST_TOO_SMALL
								: ST_TOO_LARGE;
						end
					end else begin
						ctrl_nxt.phase = PH_DIGITS;
						acc_nxt        = prod[ACC_BITS-1:0];
					end
				end else if (ctrl_cur.phase == PH_START && is_minus && signed_mode) begin
					ctrl_nxt.phase    = PH_MINUS;
					ctrl_nxt.negative = 1'b1;
				end else begin
					ctrl_nxt.phase = PH_SKIP;
					if (ctrl_cur.first_error == ST_OK) begin
						ctrl_nxt.first_error = (ctrl_cur.phase == PH_START) ? ST_BAD_START
							: ST_TRAILING;
					end
				end
			end
			default: begin
				// skipping to end of string
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/dtoi_finish.sv]
// End-of-string result: status selection, width check and sign application.
// Depends on dtoi_pkg.
`default_nettype none

module dtoi_finish import dtoi_pkg::*; #(
	parameter int ACC_BITS = 64
) (
	input  wire ctrl_t               ctrl_cur,
	input  wire logic [ACC_BITS-1:0] acc_cur,
	input  wire logic                signed_mode,
	input  wire logic [1:0]          width_select,
	output logic [VALUE_W-1:0]       value,
	output status_t                  status
);

	logic               sgn;
	logic [VALUE_W-1:0] acc64;
	logic [VALUE_W-1:0] umax;
	logic [VALUE_W-1:0] smin;
	logic [VALUE_W-1:0] lim;
	status_t            err;

	assign sgn   = ctrl_cur.negative || signed_mode;
	assign acc64 = VALUE_W'(acc_cur);

	always_comb begin
		case (width_select)
			WS_16: begin
				umax = UMAX_16;
				smin = SMIN_16;
			end
			WS_32: begin
				umax = UMAX_32;
				smin = SMIN_32;
			end
			default: begin
				umax = UMAX_64;
				smin = SMIN_64;
			end
		endcase
	end

	always_comb begin
		if (!sgn) begin
			lim = umax;
		end else if (ctrl_cur.negative) begin
			lim = smin;
		end else begin
			lim = smin - VALUE_W'(1);
		end
	end

	// empty string reports bad start unless an error is already held
	always_comb begin
		if (ctrl_cur.phase == PH_START && ctrl_cur.first_error == ST_OK) begin
			err = ST_BAD_START;
		end else begin
			err = ctrl_cur.first_error;
		end
	end

	always_comb begin
		value  = '0;
		status = err;
		if (err == ST_OK) begin
			if (acc64 > lim) begin
				status = ST_WIDTH;
			end else begin
				value = ctrl_cur.negative ? (VALUE_W'(0) - acc64) : acc64;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/decimal_text_to_integer_top.sv]
// decimal_text_to_integer_top: streaming ASCII decimal to integer converter,
// built from dtoi_step and dtoi_finish, using dtoi_pkg and the assertion
// macros in decimal_text_to_integer_top_assert.svh. One text byte arrives per
// transfer on char_in; a NUL byte ends the string and yields one transfer on
// value_out/status, every other byte yields none. In signed mode a leading '-'
// is taken and a lone '-' gives zero. Digits accumulate exactly against an
// ACC_BITS wide range; at the NUL the value is checked against the width in
// width_select (16/32/64, code 3 means 64). Status: 0 ok, 1 bad start,
// 2 too large, 3 too small, 4 trailing text, 5 does not fit width; only the
// first error is kept and value_out is zero when status is not ok. Rate: one
// character per cycle, sustained while no NUL waits on an untaken result. A
// byte is registered in the input stage, then the accumulate (shift-add
// times ten, add digit, limit compare) updates the parse state; a NUL in the
// input stage loads the result register and clears the parse state. Non-NUL
// bytes keep flowing while a result waits on out_ready; only a NUL stalls
// behind an untaken result. Config writes (cfg_index 0 signed_mode,
// 1 width_select) are always ready and belong to idle periods.
`default_nettype none

`include "decimal_text_to_integer_top_assert.svh"

module decimal_text_to_integer_top import dtoi_pkg::*; #(
	parameter int ACC_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// character input channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CHAR_W-1:0]     char_in,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [VALUE_W-1:0]         value_out,
	output logic [2:0]                 status
);

	// configuration registers
	logic       signed_mode_q;
	logic [1:0] width_select_q;

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	// parse state
	ctrl_t               ctrl_q;
	logic [ACC_BITS-1:0] acc_q;

	// result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	status_t            status_q;

	ctrl_t               ctrl_nxt;
	logic [ACC_BITS-1:0] acc_nxt;
	logic [VALUE_W-1:0]  fin_value;
	status_t             fin_status;
	logic                is_nul_s1;
	logic                advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q  <= 1'b1;
			width_select_q <= WS_64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIGNED_MODE:  signed_mode_q  <= cfg_data[0];
				REG_WIDTH_SELECT: width_select_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A NUL can only leave the input stage when the result register is free
	// or being drained this cycle; other bytes never wait.
	assign is_nul_s1 = (char_s1 == CH_NUL);
	assign advance   = valid_s1 && (!is_nul_s1 || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	dtoi_step #(
		.ACC_BITS(ACC_BITS)
	) u_step (
		.char_in    (char_s1),
		.signed_mode(signed_mode_q),
		.ctrl_cur   (ctrl_q),
		.acc_cur    (acc_q),
		.ctrl_nxt   (ctrl_nxt),
		.acc_nxt    (acc_nxt)
	);

	dtoi_finish #(
		.ACC_BITS(ACC_BITS)
	) u_finish (
		.ctrl_cur    (ctrl_q),
		.acc_cur     (acc_q),
		.signed_mode (signed_mode_q),
		.width_select(width_select_q),
		.value       (fin_value),
		.status      (fin_status)
	);

	// parse state: NUL clears back to start of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= CTRL_RESET;
			acc_q  <= '0;
		end else if (advance) begin
			if (is_nul_s1) begin
				ctrl_q <= CTRL_RESET;
				acc_q  <= '0;
			end else begin
				ctrl_q <= ctrl_nxt;
				acc_q  <= acc_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_nul_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_nul_s1) begin
			value_q  <= fin_value;
			status_q <= fin_status;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_q;
	assign status    = status_q;

	// checks on parse state and result contents
	`DTOI_ASSERT_NOW(a_err_value_zero, out_valid_q && status_q != ST_OK, value_q == '0,
		"error result carries nonzero value")
	`DTOI_ASSERT_NEXT(a_nul_clears, advance && is_nul_s1,
		ctrl_q.phase == PH_START && acc_q == '0, "state not cleared after terminator")
	`DTOI_ASSERT_NOW(a_skip_has_err, ctrl_q.phase == PH_SKIP, ctrl_q.first_error != ST_OK,
		"skip phase without a recorded error")
	`DTOI_ASSERT_NOW(a_start_clean, ctrl_q.phase == PH_START,
		acc_q == '0 && !ctrl_q.negative, "start phase with leftover value or sign")

endmodule

`default_nettype wire
